// ----- src/pft_pkg.sv -----
`timescale 1ns / 1ps
// Package for the quadratic curve core: stage records, status codes and
// the saturation helper. No dependencies.
package pft_pkg;

    localparam int ROOT_BITS = 34;
    localparam int QUOT_BITS = 34;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_SHORT_CHD = 3'd1;
    localparam logic [2:0] ST_SHORT_TAN = 3'd2;
    localparam logic [2:0] ST_BACKWARD  = 3'd3;
    localparam logic [2:0] ST_BAD_MODE  = 3'd4;

    localparam logic [1:0] MODE_CHORD = 2'd0;
    localparam logic [1:0] MODE_HALF  = 2'd1;
    localparam logic [1:0] MODE_KEEP  = 2'd2;
    localparam logic [1:0] MODE_BAD   = 2'd3;

    // Byte address of the min_length register.
    localparam logic [1:0] REG_MIN_LENGTH = 2'd0;

    localparam logic [31:0] MIN_LENGTH_RESET = 32'd66;

    typedef struct packed {
        logic [2:0][31:0] pa;
        logic [2:0][31:0] ta;
        logic [2:0][32:0] d;
        logic [1:0]       mode;
    } geom_t;

    typedef struct packed {
        geom_t                  g;
        logic [67:0]            crem;
        logic [ROOT_BITS-1:0]   croot;
        logic [67:0]            trem;
        logic [ROOT_BITS-1:0]   troot;
        logic                   neg;
    } sqrt_t;

    typedef struct packed {
        geom_t                  g;
        logic [2:0]             status;
        logic [34:0]            den;
        logic [2:0][65:0]       rem;
        logic [2:0][QUOT_BITS-1:0] q;
    } div_t;

    function automatic logic [31:0] sat32(input logic signed [36:0] v);
        logic [31:0] r;
        if (v > 37'sd2147483647) r = 32'h7FFF_FFFF;
        else if (v < -37'sd2147483648) r = 32'h8000_0000;
        else r = v[31:0];
        return r;
    endfunction

endpackage

// ----- src/parabola_from_points_tangent_core.sv -----
`timescale 1ns / 1ps
// Order of registers: stages A, B, C, square roots, D, E, divider, output.
// Throughput: one word per cycle; the 34 one-bit square root stages and
// the 34 one-bit divider stages are fully pipelined.
// The whole pipeline holds while a finished result waits at the output.
// Reset (rst_n low, asynchronous) clears all valid bits and sets
// min_length to 66.
module parabola_from_points_tangent_core
    import pft_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // Configuration port.
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [1:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // Input channel.
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] pa_x,
    input  logic signed [31:0] pa_y,
    input  logic signed [31:0] pa_z,
    input  logic signed [31:0] ta_x,
    input  logic signed [31:0] ta_y,
    input  logic signed [31:0] ta_z,
    input  logic signed [31:0] pc_x,
    input  logic signed [31:0] pc_y,
    input  logic signed [31:0] pc_z,
    input  logic [1:0]         length_mode,
    // Output channel.
    output logic               out_valid,
    input  logic               out_ready,
    output logic [2:0]         status,
    output logic signed [31:0] coef_c0_x,
    output logic signed [31:0] coef_c0_y,
    output logic signed [31:0] coef_c0_z,
    output logic signed [31:0] coef_c1_x,
    output logic signed [31:0] coef_c1_y,
    output logic signed [31:0] coef_c1_z,
    output logic signed [31:0] coef_c2_x,
    output logic signed [31:0] coef_c2_y,
    output logic signed [31:0] coef_c2_z
);

    // The single register, min_length, sits at byte address 0.
    logic [30:0] min_length_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_length_reg <= MIN_LENGTH_RESET[30:0];
        end
        else if (psel && penable && pwrite && (paddr == REG_MIN_LENGTH))
        begin
            min_length_reg <= pwdata[30:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == REG_MIN_LENGTH) ? {1'b0, min_length_reg} : 32'd0;

    // Every stage advances together; it holds only when the output word
    // is valid and not taken, so nothing is lost or repeated.
    logic adv;
    logic out_valid_reg;
    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;

    // Stage A: capture the word and form the chord vector d = pc - pa.
    geom_t a_reg;
    logic  a_valid_reg;
    geom_t a_next;

    always_comb
    begin
        a_next.pa   = {pa_z, pa_y, pa_x};
        a_next.ta   = {ta_z, ta_y, ta_x};
        a_next.d[0] = 33'({pc_x[31], pc_x} - {pa_x[31], pa_x});
        a_next.d[1] = 33'({pc_y[31], pc_y} - {pa_y[31], pa_y});
        a_next.d[2] = 33'({pc_z[31], pc_z} - {pa_z[31], pa_z});
        a_next.mode = length_mode;
    end

    // Stage B: the squares and the products of the dot product.
    geom_t            b_reg;
    logic             b_valid_reg;
    logic [2:0][65:0] b_dsq_reg;
    logic [2:0][63:0] b_tsq_reg;
    logic [2:0][64:0] b_dot_reg;
    logic [2:0][65:0] b_dsq_next;
    logic [2:0][63:0] b_tsq_next;
    logic [2:0][64:0] b_dot_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            logic [32:0] dm;
            logic [31:0] tm;
            dm = a_reg.d[i][32] ? 33'(-a_reg.d[i]) : a_reg.d[i];
            tm = a_reg.ta[i][31] ? 32'(-a_reg.ta[i]) : a_reg.ta[i];
            b_dsq_next[i] = 66'(dm) * 66'(dm);
            b_tsq_next[i] = 64'(tm) * 64'(tm);
            b_dot_next[i] = 65'($signed(a_reg.d[i]) * $signed(a_reg.ta[i]));
        end
    end

    // Stage C: the three sums; of the dot product only its sign is kept.
    sqrt_t c_next;
    logic signed [66:0] dot_sum;

    always_comb
    begin
        dot_sum = 67'($signed(b_dot_reg[0])) + 67'($signed(b_dot_reg[1]))
                + 67'($signed(b_dot_reg[2]));
        c_next.g     = b_reg;
        c_next.crem  = 68'(b_dsq_reg[0]) + 68'(b_dsq_reg[1]) + 68'(b_dsq_reg[2]);
        c_next.trem  = 68'(b_tsq_reg[0]) + 68'(b_tsq_reg[1]) + 68'(b_tsq_reg[2]);
        c_next.croot = '0;
        c_next.troot = '0;
        c_next.neg   = dot_sum[66];
    end

    // Square roots: one result bit per stage for chord and tangent. The
    // remainder holds N - root^2; a bit is set when its increment fits.
    sqrt_t sq_reg [0:ROOT_BITS];
    logic  sq_valid_reg [0:ROOT_BITS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg     <= 1'b0;
            b_valid_reg     <= 1'b0;
            sq_valid_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg     <= in_valid;
            b_valid_reg     <= a_valid_reg;
            sq_valid_reg[0] <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_reg      <= a_next;
            b_reg      <= a_reg;
            b_dsq_reg  <= b_dsq_next;
            b_tsq_reg  <= b_tsq_next;
            b_dot_reg  <= b_dot_next;
            sq_reg[0]  <= c_next;
        end
    end

    for (genvar k = 0; k < ROOT_BITS; k++)
    begin : g_sqrt
        localparam int BIT = ROOT_BITS - 1 - k;
        sqrt_t       s_next;
        logic [68:0] ctest;
        logic [68:0] ttest;

        always_comb
        begin
            s_next = sq_reg[k];
            ctest  = (69'(sq_reg[k].croot) << (BIT + 1)) + (69'(1) << (2 * BIT));
            ttest  = (69'(sq_reg[k].troot) << (BIT + 1)) + (69'(1) << (2 * BIT));
            if (ctest <= 69'(sq_reg[k].crem))
            begin
                s_next.crem       = sq_reg[k].crem - ctest[67:0];
                s_next.croot[BIT] = 1'b1;
            end
            if (ttest <= 69'(sq_reg[k].trem))
            begin
                s_next.trem       = sq_reg[k].trem - ttest[67:0];
                s_next.troot[BIT] = 1'b1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_valid_reg[k+1] <= 1'b0;
            end
            else if (adv)
            begin
                sq_valid_reg[k+1] <= sq_valid_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sq_reg[k+1] <= s_next;
            end
        end
    end

    // Stage D: checks in order, denominator, and |t_i| * chord length.
    sqrt_t            sq_last;
    geom_t            d_reg;
    logic             d_valid_reg;
    logic [2:0]       d_status_reg;
    logic [34:0]      d_den_reg;
    logic [2:0][65:0] d_num_reg;
    logic [2:0]       d_status_next;
    logic [34:0]      d_den_next;
    logic [2:0][65:0] d_num_next;

    assign sq_last = sq_reg[ROOT_BITS];

    always_comb
    begin
        priority if (sq_last.croot < ROOT_BITS'(min_length_reg))
            d_status_next = ST_SHORT_CHD;
        else if (sq_last.troot < ROOT_BITS'(min_length_reg) || sq_last.troot == '0)
            d_status_next = ST_SHORT_TAN;
        else if (sq_last.neg)
            d_status_next = ST_BACKWARD;
        else if (sq_last.g.mode == MODE_BAD)
            d_status_next = ST_BAD_MODE;
        else
            d_status_next = ST_OK;

        d_den_next = (sq_last.g.mode == MODE_HALF) ? {sq_last.troot, 1'b0}
                                                   : 35'(sq_last.troot);
        for (int i = 0; i < 3; i++)
        begin
            logic [31:0] tm;
            tm = sq_last.g.ta[i][31] ? 32'(-sq_last.g.ta[i]) : sq_last.g.ta[i];
            d_num_next[i] = 66'(tm) * 66'(sq_last.croot);
        end
    end

    // Stage E: add half the denominator for round to nearest.
    div_t e_next;

    always_comb
    begin
        e_next.g      = d_reg;
        e_next.status = d_status_reg;
        e_next.den    = d_den_reg;
        for (int i = 0; i < 3; i++)
        begin
            e_next.rem[i] = d_num_reg[i] + 66'(d_den_reg >> 1);
        end
        e_next.q = '0;
    end

    // Restoring division, one quotient bit per stage in each lane.
    div_t dv_reg [0:QUOT_BITS];
    logic dv_valid_reg [0:QUOT_BITS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg     <= 1'b0;
            dv_valid_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            d_valid_reg     <= sq_valid_reg[ROOT_BITS];
            dv_valid_reg[0] <= d_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_reg        <= sq_last.g;
            d_status_reg <= d_status_next;
            d_den_reg    <= d_den_next;
            d_num_reg    <= d_num_next;
            dv_reg[0]    <= e_next;
        end
    end

    for (genvar k = 0; k < QUOT_BITS; k++)
    begin : g_div
        localparam int BIT = QUOT_BITS - 1 - k;
        div_t        v_next;
        logic [67:0] sub;

        always_comb
        begin
            v_next = dv_reg[k];
            sub    = 68'(dv_reg[k].den) << BIT;
            for (int i = 0; i < 3; i++)
            begin
                if (68'(dv_reg[k].rem[i]) >= sub)
                begin
                    v_next.rem[i]    = dv_reg[k].rem[i] - sub[65:0];
                    v_next.q[i][BIT] = 1'b1;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_valid_reg[k+1] <= 1'b0;
            end
            else if (adv)
            begin
                dv_valid_reg[k+1] <= dv_valid_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_reg[k+1] <= v_next;
            end
        end
    end

    // Output stage: sign the quotient (or take t as it is in keep mode), form
    // c2 = d - c1, saturate, and zero every coefficient when a check failed.
    div_t             dv_last;
    logic [2:0]       status_reg;
    logic [2:0][31:0] c0_reg;
    logic [2:0][31:0] c1_reg;
    logic [2:0][31:0] c2_reg;
    logic [2:0][31:0] c0_next;
    logic [2:0][31:0] c1_next;
    logic [2:0][31:0] c2_next;

    assign dv_last = dv_reg[QUOT_BITS];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            logic signed [36:0] c1w;
            logic signed [36:0] c2w;
            if (dv_last.g.mode == MODE_KEEP)
                c1w = 37'($signed(dv_last.g.ta[i]));
            else if (dv_last.g.ta[i][31])
                c1w = -$signed(37'(dv_last.q[i]));
            else
                c1w = $signed(37'(dv_last.q[i]));
            c2w = 37'($signed(dv_last.g.d[i])) - c1w;
            if (dv_last.status == ST_OK)
            begin
                c0_next[i] = dv_last.g.pa[i];
                c1_next[i] = sat32(c1w);
                c2_next[i] = sat32(c2w);
            end
            else
            begin
                c0_next[i] = '0;
                c1_next[i] = '0;
                c2_next[i] = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= dv_valid_reg[QUOT_BITS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            status_reg <= dv_last.status;
            c0_reg     <= c0_next;
            c1_reg     <= c1_next;
            c2_reg     <= c2_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign coef_c0_x = c0_reg[0];
    assign coef_c0_y = c0_reg[1];
    assign coef_c0_z = c0_reg[2];
    assign coef_c1_x = c1_reg[0];
    assign coef_c1_y = c1_reg[1];
    assign coef_c1_z = c1_reg[2];
    assign coef_c2_x = c2_reg[0];
    assign coef_c2_y = c2_reg[1];
    assign coef_c2_z = c2_reg[2];

endmodule

// ----- test/parabola_from_points_tangent_checker.sv -----
`timescale 1ns / 1ps
// Checker for the quadratic curve core: watches the config port and both word
// channels, predicts each result and compares it. Depends on pft_pkg.
module parabola_from_points_tangent_checker
    import pft_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [1:0]         paddr,
    input  logic [31:0]        pwdata,
    input  logic               pready,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic signed [31:0] pa_x, pa_y, pa_z,
    input  logic signed [31:0] ta_x, ta_y, ta_z,
    input  logic signed [31:0] pc_x, pc_y, pc_z,
    input  logic [1:0]         length_mode,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic [2:0]         status,
    input  logic signed [31:0] coef_c0_x, coef_c0_y, coef_c0_z,
    input  logic signed [31:0] coef_c1_x, coef_c1_y, coef_c1_z,
    input  logic signed [31:0] coef_c2_x, coef_c2_y, coef_c2_z,
    output int                 errors,
    output int                 pending
);

    typedef struct packed {
        logic [2:0]       st;
        logic [2:0][31:0] c0;
        logic [2:0][31:0] c1;
        logic [2:0][31:0] c2;
    } curve_t;

    curve_t      curve_q[$];
    logic [30:0] min_len;

    assign pending = curve_q.size();

    function automatic logic [33:0] floor_root(input logic [67:0] v);
        logic [33:0] r;
        logic [33:0] c;
        r = '0;
        for (int b = 33; b >= 0; b--)
        begin
            c = r | (34'd1 << b);
            if (68'(c) * 68'(c) <= v) r = c;
        end
        return r;
    endfunction

    function automatic logic [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'h8000_0000;
        return v[31:0];
    endfunction

    function automatic curve_t fit_curve(input logic [2:0][31:0] pa, input logic [2:0][31:0] ta,
                                         input logic [2:0][31:0] pc, input logic [1:0] mode,
                                         input logic [30:0] lim);
        curve_t             r;
        longint             d[3];
        longint             t[3];
        longint             c1;
        logic [67:0]        chord_sq;
        logic [67:0]        tan_sq;
        logic [67:0]        m;
        logic signed [69:0] dot;
        logic [33:0]        clen;
        logic [33:0]        tlen;
        logic [63:0]        den;
        logic [63:0]        num;
        logic [63:0]        q;
        r = '0;
        chord_sq = '0;
        tan_sq = '0;
        dot = '0;
        for (int i = 0; i < 3; i++)
        begin
            d[i] = longint'($signed(pc[i])) - longint'($signed(pa[i]));
            t[i] = longint'($signed(ta[i]));
            m = d[i] < 0 ? 68'(-d[i]) : 68'(d[i]);
            chord_sq += m * m;
            m = t[i] < 0 ? 68'(-t[i]) : 68'(t[i]);
            tan_sq += m * m;
            dot += 70'(d[i]) * 70'(t[i]);
        end
        clen = floor_root(chord_sq);
        tlen = floor_root(tan_sq);
        if (clen < lim) r.st = ST_SHORT_CHD;
        else if (tlen < lim || tlen == 0) r.st = ST_SHORT_TAN;
        else if (dot < 0) r.st = ST_BACKWARD;
        else if (mode == MODE_BAD) r.st = ST_BAD_MODE;
        else r.st = ST_OK;
        if (r.st != ST_OK) return r;
        for (int i = 0; i < 3; i++)
        begin
            if (mode == MODE_KEEP)
                c1 = t[i];
            else
            begin
                den = (mode == MODE_HALF) ? 64'(tlen) * 2 : 64'(tlen);
                // The magnitude product wraps at 64 bits, as does the rounding add.
                num = 64'(t[i] < 0 ? -t[i] : t[i]) * 64'(clen);
                q = (num + den / 2) / den;
                c1 = t[i] < 0 ? -longint'(q) : longint'(q);
            end
            r.c0[i] = pa[i];
            r.c1[i] = clamp32(c1);
            r.c2[i] = clamp32(d[i] - c1);
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        curve_t exp_c;
        curve_t got;
        if (!rst_n)
        begin
            min_len <= MIN_LENGTH_RESET[30:0];
            errors  <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == REG_MIN_LENGTH)
                min_len <= pwdata[30:0];
            if (in_valid && in_ready)
                curve_q.push_back(fit_curve({pa_z, pa_y, pa_x}, {ta_z, ta_y, ta_x},
                                            {pc_z, pc_y, pc_x}, length_mode, min_len));
            if (out_valid && out_ready)
            begin
                got.st = status;
                got.c0 = {coef_c0_z, coef_c0_y, coef_c0_x};
                got.c1 = {coef_c1_z, coef_c1_y, coef_c1_x};
                got.c2 = {coef_c2_z, coef_c2_y, coef_c2_x};
                if (curve_q.size() == 0)
                begin
                    $error("result word with nothing expected");
                    errors <= errors + 1;
                end
                else
                begin
                    exp_c = curve_q.pop_front();
                    if (got != exp_c)
                    begin
                        errors <= errors + 1;
                        if (got.st != exp_c.st)
                            $error("status: expected %0d, got %0d", exp_c.st, got.st);
                        for (int i = 0; i < 3; i++)
                        begin
                            if (got.c0[i] != exp_c.c0[i])
                                $error("coef_c0[%0d]: expected %h, got %h", i, exp_c.c0[i],
                                       got.c0[i]);
                            if (got.c1[i] != exp_c.c1[i])
                                $error("coef_c1[%0d]: expected %h, got %h", i, exp_c.c1[i],
                                       got.c1[i]);
                            if (got.c2[i] != exp_c.c2[i])
                                $error("coef_c2[%0d]: expected %h, got %h", i, exp_c.c2[i],
                                       got.c2[i]);
                        end
                    end
                end
            end
        end
    end

endmodule

// ----- test/parabola_from_points_tangent_core_tb.sv -----
`timescale 1ns / 1ps
// Top of the quadratic curve core testbench: drives config writes and input
// words, stalls the output, gives the verdict. Depends on the core, pft_pkg
// and parabola_from_points_tangent_checker.
module parabola_from_points_tangent_core_tb
    import pft_pkg::*;
();

    // Settling time after the last result, longer than the core's pipeline.
    localparam int DRAIN_CYCLES = 100;

    logic               clk;
    logic               rst_n;
    logic               psel, penable, pwrite;
    logic [1:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               in_valid, in_ready;
    logic signed [31:0] pa_x, pa_y, pa_z, ta_x, ta_y, ta_z, pc_x, pc_y, pc_z;
    logic [1:0]         length_mode;
    logic               out_valid, out_ready;
    logic [2:0]         status;
    logic signed [31:0] coef_c0_x, coef_c0_y, coef_c0_z;
    logic signed [31:0] coef_c1_x, coef_c1_y, coef_c1_z;
    logic signed [31:0] coef_c2_x, coef_c2_y, coef_c2_z;
    int                 errors;
    int                 pending;

    // Steering of both sides: calm turns off all random idling, and
    // long_hold asks the receiver for one long stall.
    bit                 calm;
    bit                 long_hold;

    parabola_from_points_tangent_core i_dut (.*);
    parabola_from_points_tangent_checker i_chk (.*);

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    initial
    begin
        #(12 * 600000);
        $display("DONE: errors detected");
        $finish;
    end

    // Receiver: a random stall before each word, or one long stall when asked.
    initial
    begin
        int n;
        out_ready = 1'b0;
        @(posedge clk iff rst_n);
        forever
        begin
            if (long_hold)
            begin
                out_ready <= 1'b0;
                repeat (400) @(posedge clk);
                long_hold = 1'b0;
            end
            n = calm ? 0 : $urandom_range(0, 11);
            if (n > 0)
            begin
                out_ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    task automatic write_min_length(input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_MIN_LENGTH;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // Offers one word after a random gap and holds it until it is taken.
    // Valid is only lowered when a gap follows, so it never bounces in one step.
    task automatic send_word(input logic [2:0][31:0] pa, input logic [2:0][31:0] ta,
                             input logic [2:0][31:0] pc, input logic [1:0] mode);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        {pa_z, pa_y, pa_x} <= pa;
        {ta_z, ta_y, ta_x} <= ta;
        {pc_z, pc_y, pc_x} <= pc;
        length_mode <= mode;
        do @(posedge clk); while (!in_ready);
    endtask

    // Waits until every expected result has come, then lets the pipeline settle.
    task automatic drain;
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Random curve: mostly a tangent roughly along the chord, at a small or a
    // full scale, with some pure noise and deliberately bad words mixed in.
    task automatic send_random;
        logic [2:0][31:0] pa, ta, pc;
        logic [1:0]       mode;
        int               kind;
        int               sh;
        longint           dot;
        kind = $urandom_range(0, 9);
        sh = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(8, 24);
        mode = $urandom_range(0, 9) == 0 ? MODE_BAD : 2'($urandom_range(0, 2));
        dot = 0;
        for (int i = 0; i < 3; i++)
        begin
            pa[i] = $signed($urandom()) >>> sh;
            pc[i] = $signed($urandom()) >>> sh;
            ta[i] = $signed($urandom()) >>> (kind == 9 ? 28 : sh);
            dot += (longint'($signed(pc[i])) - $signed(pa[i])) / 65536 *
                   (longint'($signed(ta[i])) / 65536);
        end
        if (kind < 7 && dot < 0)
            for (int i = 0; i < 3; i++) ta[i] = -$signed(ta[i]);
        if (kind == 8) pc = pa;
        send_word(pa, ta, pc, mode);
    endtask

    initial
    begin
        logic [2:0][31:0] z3, mx3, mn3, one3;
        z3   = '0;
        mx3  = {3{32'h7FFF_FFFF}};
        mn3  = {3{32'h8000_0000}};
        one3 = {3{32'h0001_0000}};
        rst_n = 1'b0;
        calm = 1'b0;
        long_hold = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        {pa_x, pa_y, pa_z, ta_x, ta_y, ta_z, pc_x, pc_y, pc_z} = '0;
        length_mode = MODE_CHORD;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words at the reset tolerance.
        for (int m = 0; m < 4; m++)
            send_word(z3, one3, {32'h0, 32'h0, 32'h0003_0000}, 2'(m));
        send_word(mn3, mx3, mx3, MODE_CHORD);
        send_word(mn3, mx3, mx3, MODE_HALF);
        send_word(mn3, mx3, mx3, MODE_KEEP);
        send_word(mx3, mn3, mn3, MODE_CHORD);
        send_word(mx3, mx3, mn3, MODE_KEEP);
        send_word(mn3, mn3, mx3, MODE_KEEP);
        send_word(one3, one3, one3, MODE_CHORD);
        send_word(z3, z3, one3, MODE_CHORD);
        send_word(z3, {32'h0, 32'h0, 32'sh0000_0041}, one3, MODE_CHORD);
        send_word(z3, {3{32'hFFFF_0000}}, one3, MODE_CHORD);
        send_word(z3, {32'h0, 32'h0001_0000, 32'h0}, {32'h0, 32'h0, 32'h0001_0000},
                  MODE_HALF);
        send_word(z3, {32'h0, 32'h0, 32'sh0000_0001}, {32'h0, 32'h0, 32'h7FFF_FFFF},
                  MODE_CHORD);
        drain();

        write_min_length(32'd0);
        send_word(z3, z3, z3, MODE_CHORD);
        send_word(z3, one3, z3, MODE_KEEP);
        send_word(z3, one3, z3, MODE_CHORD);
        send_word(z3, z3, one3, MODE_HALF);
        drain();

        write_min_length(32'h7FFF_FFFF);
        send_word(mn3, mx3, mx3, MODE_CHORD);
        send_word(z3, one3, one3, MODE_CHORD);
        for (int n = 0; n < 40; n++) send_random();
        drain();

        // Random phases over several tolerances.
        for (int ph = 0; ph < 6; ph++)
        begin
            write_min_length(ph == 0 ? 32'd66 : ph == 1 ? 32'd0 : $urandom_range(0, 1 << 20));
            calm = (ph == 3);
            for (int n = 0; n < 200; n++) send_random();
            drain();
        end
        calm = 1'b0;

        // Back pressure: the receiver stops for a long time while words keep
        // coming, so the pipeline fills and in_ready drops.
        write_min_length(32'd66);
        long_hold = 1'b1;
        for (int n = 0; n < 250; n++) send_random();
        drain();

        for (int n = 0; n < 200; n++) send_random();
        drain();

        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
